// File: design/lagged_fibonacci_xor_rng_assert.svh
// assertion macros for the lagged fibonacci xor generator checker
// expects clk and rst_n in the scope where the macros are used
`ifndef LAGGED_FIBONACCI_XOR_RNG_ASSERT_SVH
`define LAGGED_FIBONACCI_XOR_RNG_ASSERT_SVH

// same-cycle implication
`define LFX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfx assertion failed");

// next-cycle implication
`define LFX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfx assertion failed");

`endif

// File: design/lfx_pkg.sv
// shared types and constants for the lagged fibonacci xor generator
// no dependencies
package lfx_pkg;

  typedef enum logic [1:0] {
    CMD_NEXT   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SETPOS = 2'd3
  } lfx_cmd_t;

  localparam logic [31:0] STATE_MAGIC = 32'd21796;

  typedef struct packed {
    lfx_cmd_t    command;
    logic [5:0]  index;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] number;
    logic [5:0]  position;
    logic        error;
  } out_word_t;

endpackage

// File: design/lagged_fibonacci_xor_rng.sv
// top level of the lagged fibonacci xor random generator
// uses lfx_pkg and lfx_table
//
// in_word carries a command, an index and a value; each accepted word gives
// exactly one out_word with the number, the lead position and an error flag.
// next: advance the lead position, xor the lag word into the lead word,
// store and return it. write/read: one table word by index. set position:
// needs the magic value and an index below the depth.
// each word goes through the table's registered read, then the write-back
// with the result; the block takes no new word until the last one is done.
// one word is in flight at a time; in_ready is high whenever the block is
// waiting for a command, even while an earlier result still waits.
// if out_ready stays low, the finished result is held in the output register
// and the next command waits in its execute state until the register frees.
// reset: position zero, every table word reads as zero at once through
// per-entry valid flags, so no clearing pass is needed.
module lagged_fibonacci_xor_rng #(
  parameter int TABLE_DEPTH = 55,
  parameter int LAG_OFFSET  = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfx_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output lfx_pkg::out_word_t out_word
);
  import lfx_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int LAG_MOD = LAG_OFFSET % TABLE_DEPTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] lead_r, lead_nxt;
  logic [AW-1:0] cand_r;
  lfx_cmd_t      cmd_r;
  logic [AW-1:0] idx_r;
  logic [31:0]   val_r;
  logic          ok_r;
  out_word_t     out_word_r, out_word_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          accept;
  logic          finish;
  logic          idx_ok;
  logic [AW-1:0] lead_inc;
  logic [AW:0]   lag_sum;
  logic [AW-1:0] lag_addr;
  logic [AW-1:0] rd_addr_a;
  logic [31:0]   rd_data_a;
  logic [31:0]   rd_data_b;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   number;
  logic          err;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign idx_ok   = 32'(in_word.index) < TABLE_DEPTH;

  assign lead_inc = (lead_r == AW'(TABLE_DEPTH - 1)) ? '0 : lead_r + AW'(1);
  assign lag_sum  = {1'b0, lead_inc} + (AW+1)'(LAG_MOD);
  assign lag_addr = (lag_sum >= (AW+1)'(TABLE_DEPTH)) ?
                    AW'(lag_sum - (AW+1)'(TABLE_DEPTH)) : AW'(lag_sum);

  always_comb begin
    if (in_word.command == CMD_NEXT) begin
      rd_addr_a = lead_inc;
    end else if (idx_ok) begin
      rd_addr_a = AW'(in_word.index);
    end else begin
      rd_addr_a = '0;
    end
  end

  lfx_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (lag_addr),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = val_r;
    number   = 32'd0;
    err      = 1'b0;
    lead_nxt = lead_r;
    case (cmd_r)
      CMD_NEXT: begin
        wr_en    = finish;
        wr_addr  = cand_r;
        wr_data  = rd_data_a ^ rd_data_b;
        number   = rd_data_a ^ rd_data_b;
        lead_nxt = cand_r;
      end
      CMD_WRITE: begin
        wr_en = finish && ok_r;
        err   = !ok_r;
      end
      CMD_READ: begin
        number = ok_r ? rd_data_a : 32'd0;
        err    = !ok_r;
      end
      CMD_SETPOS: begin
        if (ok_r && (val_r == STATE_MAGIC)) begin
          lead_nxt = idx_r;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_nxt             = S_IDLE;
          out_valid_nxt         = 1'b1;
          out_word_nxt.number   = number;
          out_word_nxt.position = 6'(lead_nxt);
          out_word_nxt.error    = err;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lead_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        lead_r <= lead_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (accept) begin
      cmd_r  <= in_word.command;
      idx_r  <= idx_ok ? AW'(in_word.index) : '0;
      val_r  <= in_word.value;
      ok_r   <= idx_ok;
      cand_r <= lead_inc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: design/lfx_table.sv
// word table: one write port, two registered read ports
// per-entry valid flags make unwritten entries read as zero; uses lfx_pkg
module lfx_table #(
  parameter int DEPTH = 55,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [31:0]   rd_data_a,
  output logic [31:0]   rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);
  import lfx_pkg::*;

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [31:0]      data_a_r;
  logic [31:0]      data_b_r;
  logic             ok_a_r;
  logic             ok_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_a_r <= mem[rd_addr_a];
      data_b_r <= mem[rd_addr_b];
      ok_a_r   <= vld_r[rd_addr_a];
      ok_b_r   <= vld_r[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data_a = ok_a_r ? data_a_r : 32'd0;
  assign rd_data_b = ok_b_r ? data_b_r : 32'd0;

endmodule

// File: design/lfx_checker.sv
// port-level checker for the lagged fibonacci xor generator, bound to the top
// uses lfx_pkg and lagged_fibonacci_xor_rng_assert.svh
`include "lagged_fibonacci_xor_rng_assert.svh"

module lfx_checker #(
  parameter int TABLE_DEPTH = 55
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lfx_pkg::out_word_t out_word
);
  import lfx_pkg::*;

  // a stalled result holds
  `LFX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // one command in flight at a time
  `LFX_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a failed check never returns a word
  `LFX_ASSERT_NOW(a_err_zero, out_valid && out_word.error, out_word.number == 32'd0)

  // the position stays inside the table when the depth is at most 64
  `LFX_ASSERT_NOW(a_pos_range, out_valid && (TABLE_DEPTH <= 64),
                  32'(out_word.position) < TABLE_DEPTH)

endmodule

bind lagged_fibonacci_xor_rng lfx_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_lfx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
